// ===== rtl/ted_pkg.sv =====
// Shared types, constants and the exponential factor table for the truncated exponential density.
package ted_pkg;

   localparam int EXP_TABLE_BITS = 6;
   localparam int TBL_SIZE       = 5 + EXP_TABLE_BITS;
   localparam int R_BITS         = 32 - EXP_TABLE_BITS;

   localparam logic [31:0] SAT_WORD = 32'hFFFF_FFFF;
   localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;

   // Divider: numerators reach 2^56 plus half the divisor.
   localparam int DIV_BITS = 57;
   localparam int CNT_BITS = $clog2(DIV_BITS);

   // Pipeline stage positions
   localparam int ST_DIST = 1;
   localparam int ST_PROD = 2;
   localparam int ST_FAC0 = 3;
   localparam int ST_RFIX = ST_FAC0 + TBL_SIZE;
   localparam int ST_DIFF = ST_RFIX + 1;
   localparam int ST_MULT = ST_DIFF + 1;
   localparam int NST     = ST_MULT + 1;

   // Register indexes
   localparam logic [2:0] CSR_DECAY_RATE   = 3'd0;
   localparam logic [2:0] CSR_LOWER_ENABLE = 3'd1;
   localparam logic [2:0] CSR_LOWER_BOUND  = 3'd2;
   localparam logic [2:0] CSR_UPPER_ENABLE = 3'd3;
   localparam logic [2:0] CSR_UPPER_BOUND  = 3'd4;

   typedef enum logic [1:0] {
      DRV_IDLE,
      DRV_INJECT,
      DRV_WAIT,
      DRV_DIVIDE
   } drv_state_type;

   typedef struct packed {
      logic               valid;
      logic               derive;
      logic               op;
      logic               blank;
      logic signed [31:0] xa;
      logic signed [31:0] xb;
      logic [31:0]        da;
      logic [31:0]        db;
      logic [63:0]        pa;
      logic [63:0]        pb;
      logic [32:0]        ea;
      logic [32:0]        eb;
      logic [32:0]        e;
      logic [31:0]        res;
      logic               sat;
   } pipe_type;

   typedef logic [31:0] exp_tbl_type [TBL_SIZE];

   // exp(-2^(4-k)) in Q0.32: fine factors from the alternating series, coarse ones by squaring
   function automatic exp_tbl_type build_exp_tbl();
      exp_tbl_type tbl;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] sq;
      for (int k = 4; k < TBL_SIZE; k++) begin
         sum  = 64'd1 << 62;
         term = 64'd1 << 62;
         for (int n = 1; n < 40; n++) begin
            term = (term >> (k - 4)) / 64'(n);
            if ((n % 2) == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         tbl[k] = 32'((sum + (64'd1 << 29)) >> 30);
      end
      for (int k = 3; k >= 0; k--) begin
         sq     = 64'(tbl[k + 1]) * 64'(tbl[k + 1]);
         tbl[k] = 32'((sq + (64'd1 << 31)) >> 32);
      end
      return tbl;
   endfunction

   localparam exp_tbl_type EXP_TBL = build_exp_tbl();

endpackage

// ===== rtl/truncated_exponential_density.sv =====
// Top level: pipelined truncated exponential density and area with normaliser derivation.
//
//  channel | direction | tdata / data                      | tuser
//  req     | in        | [31:0] point, [63:32] range_end    | op
//  rsp     | out       | [31:0] result_value                | saturated
//  csr     | in        | csr_index (register), csr_wdata    | -
//
// One request per cycle while no register write or derivation is pending and the output does not
// stall; the request enters the first of 17 stages and the output register follows the last. Most
// of the depth is the chain of eleven table multiplies and the final scale.
// Each register write settles the normalisers as follows: the exponent
// runs through the pipeline once, then a one-bit-per-cycle divider runs 57 steps.
// Reset is synchronous; the normalisers reset to their derived values at once.
// A stalled output register holds; the stages behind it close up their bubbles.
module truncated_exponential_density (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] point, [63:32] range_end
   input  logic        req_tuser,   // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic        rsp_tuser,   // saturated
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int LAST = ted_pkg::NST - 1;

   // configuration
   logic [31:0]        decay_rate_ff;
   logic               lower_enable_ff;
   logic signed [31:0] lower_bound_ff;
   logic               upper_enable_ff;
   logic signed [31:0] upper_bound_ff;
   logic [31:0]        inv_norm_ff;
   logic [31:0]        inv_rate_ff;

   ted_pkg::drv_state_type drv_state_ff, drv_state_in;
   logic                   inject;
   logic                   csr_accept;
   logic                   tok_done;

   ted_pkg::pipe_type pipe_ff [ted_pkg::NST];
   ted_pkg::pipe_type pipe_in [ted_pkg::NST];
   logic [ted_pkg::NST-1:0] ce;
   logic [ted_pkg::NST-1:0] tok_vec;
   logic                    out_ce;
   logic                    req_accept;

   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;
   logic        rsp_sat_ff;

   // divider
   logic [ted_pkg::CNT_BITS-1:0] cnt_ff;
   logic [ted_pkg::DIV_BITS-1:0] n1_ff, n2_ff, n1_in, n2_in;
   logic [32:0]                  rem1_ff, rem2_ff, rem1_in, rem2_in;
   logic [32:0]                  den_ff, den_start;
   logic [33:0]                  trial1, trial2;
   logic                         ge1, ge2;

   // ---------------------------------------------------------------- handshakes
   assign out_ce     = !rsp_valid_ff || rsp_tready;
   assign tok_done   = pipe_ff[LAST].valid && pipe_ff[LAST].derive;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      ce[LAST] = !pipe_ff[LAST].valid || pipe_ff[LAST].derive || out_ce;
      for (int i = LAST - 1; i >= 0; i--) begin
         ce[i] = !pipe_ff[i].valid || ce[i + 1];
      end
   end

   always_comb begin
      for (int i = 0; i < ted_pkg::NST; i++) begin
         tok_vec[i] = pipe_ff[i].valid && pipe_ff[i].derive;
      end
   end

   // ---------------------------------------------------------------- derive sequencer
   always_comb begin
      drv_state_in = drv_state_ff;
      case (drv_state_ff)
         ted_pkg::DRV_IDLE: begin
            if (csr_tvalid) drv_state_in = ted_pkg::DRV_INJECT;
         end
         ted_pkg::DRV_INJECT: begin
            if (ce[0]) drv_state_in = ted_pkg::DRV_WAIT;
         end
         ted_pkg::DRV_WAIT: begin
            if (tok_done) drv_state_in = ted_pkg::DRV_DIVIDE;
         end
         ted_pkg::DRV_DIVIDE: begin
            if (cnt_ff == ted_pkg::CNT_BITS'(ted_pkg::DIV_BITS - 1)) begin
               drv_state_in = ted_pkg::DRV_IDLE;
            end
         end
         default: drv_state_in = ted_pkg::DRV_IDLE;
      endcase
   end

   always_comb begin
      csr_tready = 1'b0;
      inject     = 1'b0;
      req_tready = 1'b0;
      case (drv_state_ff)
         ted_pkg::DRV_IDLE: begin
            csr_tready = 1'b1;
            req_tready = !csr_tvalid && ce[0];
         end
         ted_pkg::DRV_INJECT: begin
            inject = ce[0];
         end
         default: begin
            csr_tready = 1'b0;
         end
      endcase
   end

   assign csr_accept = csr_tvalid && csr_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         drv_state_ff <= ted_pkg::DRV_IDLE;
      end else begin
         drv_state_ff <= drv_state_in;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         decay_rate_ff   <= 32'h0100_0000;
         lower_enable_ff <= 1'b0;
         lower_bound_ff  <= '0;
         upper_enable_ff <= 1'b0;
         upper_bound_ff  <= '0;
      end else if (csr_accept) begin
         case (csr_index)
            ted_pkg::CSR_DECAY_RATE:   decay_rate_ff   <= csr_wdata;
            ted_pkg::CSR_LOWER_ENABLE: lower_enable_ff <= csr_wdata[0];
            ted_pkg::CSR_LOWER_BOUND:  lower_bound_ff  <= csr_wdata;
            ted_pkg::CSR_UPPER_ENABLE: upper_enable_ff <= csr_wdata[0];
            ted_pkg::CSR_UPPER_BOUND:  upper_bound_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- pipeline stages
   always_comb begin
      pipe_in[0]        = pipe_ff[0];
      pipe_in[0].valid  = req_accept || inject;
      pipe_in[0].derive = inject;
      pipe_in[0].op     = req_tuser;
      pipe_in[0].xa     = req_tdata[31:0];
      pipe_in[0].xb     = req_tdata[63:32];
   end

   for (genvar i = 1; i < ted_pkg::NST; i++) begin : g_stage
      if (i == ted_pkg::ST_DIST) begin : g_dist
         logic signed [32:0] lo33, x33, re33, u33, a33, b33;
         always_comb begin
            lo33 = lower_enable_ff ? 33'(lower_bound_ff) : '0;
            x33  = 33'(pipe_ff[i-1].xa);
            re33 = 33'(pipe_ff[i-1].xb);
            u33  = 33'(upper_bound_ff);
            a33  = (x33 > lo33) ? x33 : lo33;
            b33  = (upper_enable_ff && re33 > u33) ? u33 : re33;
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].derive) begin
               pipe_in[i].op    = 1'b0;
               pipe_in[i].blank = !upper_enable_ff;
               pipe_in[i].da    = (u33 > lo33) ? 32'(u33 - lo33) : '0;
               pipe_in[i].db    = '0;
            end else if (!pipe_ff[i-1].op) begin
               pipe_in[i].blank = (x33 < lo33) || (upper_enable_ff && x33 > u33);
               pipe_in[i].da    = 32'(x33 - lo33);
               pipe_in[i].db    = '0;
            end else begin
               pipe_in[i].blank = (b33 <= a33);
               pipe_in[i].da    = 32'(a33 - lo33);
               pipe_in[i].db    = 32'(b33 - lo33);
            end
         end
      end else if (i == ted_pkg::ST_PROD) begin : g_prod
         always_comb begin
            pipe_in[i]    = pipe_ff[i-1];
            pipe_in[i].pa = 64'(decay_rate_ff) * 64'(pipe_ff[i-1].da);
            pipe_in[i].pb = 64'(decay_rate_ff) * 64'(pipe_ff[i-1].db);
            pipe_in[i].ea = ted_pkg::ONE_Q32;
            pipe_in[i].eb = ted_pkg::ONE_Q32;
         end
      end else if (i < ted_pkg::ST_RFIX) begin : g_fac
         // factor exp(-2^(4-k)) for exponent bit 44-k
         logic [64:0] ma, mb;
         always_comb begin
            ma = 65'(pipe_ff[i-1].ea) * 65'(ted_pkg::EXP_TBL[i - ted_pkg::ST_FAC0])
                 + (65'd1 << 31);
            mb = 65'(pipe_ff[i-1].eb) * 65'(ted_pkg::EXP_TBL[i - ted_pkg::ST_FAC0])
                 + (65'd1 << 31);
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].pa[44 - (i - ted_pkg::ST_FAC0)]) pipe_in[i].ea = ma[64:32];
            if (pipe_ff[i-1].pb[44 - (i - ted_pkg::ST_FAC0)]) pipe_in[i].eb = mb[64:32];
         end
      end else if (i == ted_pkg::ST_RFIX) begin : g_rfix
         // linear term for the leftover fraction, and underflow to zero
         logic [32:0] fa, fb;
         logic [65:0] ma, mb;
         always_comb begin
            fa = ted_pkg::ONE_Q32 - 33'(pipe_ff[i-1].pa[39 - ted_pkg::EXP_TABLE_BITS:8]);
            fb = ted_pkg::ONE_Q32 - 33'(pipe_ff[i-1].pb[39 - ted_pkg::EXP_TABLE_BITS:8]);
            ma = 66'(pipe_ff[i-1].ea) * 66'(fa) + (66'd1 << 31);
            mb = 66'(pipe_ff[i-1].eb) * 66'(fb) + (66'd1 << 31);
            pipe_in[i]    = pipe_ff[i-1];
            pipe_in[i].ea = (|pipe_ff[i-1].pa[63:45]) ? '0 : ma[64:32];
            pipe_in[i].eb = (|pipe_ff[i-1].pb[63:45]) ? '0 : mb[64:32];
         end
      end else if (i == ted_pkg::ST_DIFF) begin : g_diff
         always_comb begin
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].blank) begin
               pipe_in[i].e = '0;
            end else if (!pipe_ff[i-1].op) begin
               pipe_in[i].e = pipe_ff[i-1].ea;
            end else if (pipe_ff[i-1].ea > pipe_ff[i-1].eb) begin
               pipe_in[i].e = pipe_ff[i-1].ea - pipe_ff[i-1].eb;
            end else begin
               pipe_in[i].e = '0;
            end
         end
      end else begin : g_mult
         logic [31:0] k;
         logic [64:0] m;
         always_comb begin
            k = pipe_ff[i-1].op ? inv_rate_ff : inv_norm_ff;
            m = 65'(pipe_ff[i-1].e) * 65'(k) + (65'd1 << 31);
            pipe_in[i] = pipe_ff[i-1];
            if (k == ted_pkg::SAT_WORD) begin
               pipe_in[i].res = (pipe_ff[i-1].e != '0) ? ted_pkg::SAT_WORD : '0;
               pipe_in[i].sat = (pipe_ff[i-1].e != '0);
            end else begin
               pipe_in[i].res = m[63:32];
               pipe_in[i].sat = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ted_pkg::NST; i++) begin
         if (reset) begin
            pipe_ff[i].valid <= 1'b0;
         end else if (ce[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ce) begin
         rsp_valid_ff <= pipe_ff[LAST].valid && !pipe_ff[LAST].derive;
      end
      if (out_ce) begin
         rsp_data_ff <= pipe_ff[LAST].res;
         rsp_sat_ff  <= pipe_ff[LAST].sat;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // ---------------------------------------------------------------- normaliser divider
   assign den_start = ted_pkg::ONE_Q32 - pipe_ff[LAST].e;
   assign trial1    = {rem1_ff, n1_ff[ted_pkg::DIV_BITS-1]};
   assign trial2    = {rem2_ff, n2_ff[ted_pkg::DIV_BITS-1]};
   assign ge1       = trial1 >= {1'b0, den_ff};
   assign ge2       = trial2 >= {1'b0, den_ff};
   assign rem1_in   = ge1 ? 33'(trial1 - {1'b0, den_ff}) : trial1[32:0];
   assign rem2_in   = ge2 ? 33'(trial2 - {1'b0, den_ff}) : trial2[32:0];
   assign n1_in     = {n1_ff[ted_pkg::DIV_BITS-2:0], ge1};
   assign n2_in     = {n2_ff[ted_pkg::DIV_BITS-2:0], ge2};

   always_ff @(posedge clock) begin
      if (reset) begin
         inv_norm_ff <= 32'h0001_0000;
         inv_rate_ff <= 32'h0001_0000;
         cnt_ff      <= '0;
      end else if (drv_state_ff == ted_pkg::DRV_WAIT && tok_done) begin
         // quotients rounded to nearest: add half the divisor up front
         den_ff  <= den_start;
         n1_ff   <= (ted_pkg::DIV_BITS'(1) << 48) + ted_pkg::DIV_BITS'(den_start >> 1);
         n2_ff   <= ted_pkg::DIV_BITS'({decay_rate_ff, 24'd0})
                    + ted_pkg::DIV_BITS'(den_start >> 1);
         rem1_ff <= '0;
         rem2_ff <= '0;
         cnt_ff  <= '0;
      end else if (drv_state_ff == ted_pkg::DRV_DIVIDE) begin
         n1_ff   <= n1_in;
         n2_ff   <= n2_in;
         rem1_ff <= rem1_in;
         rem2_ff <= rem2_in;
         cnt_ff  <= cnt_ff + 1'b1;
         if (cnt_ff == ted_pkg::CNT_BITS'(ted_pkg::DIV_BITS - 1)) begin
            inv_rate_ff <= (n1_in >= ted_pkg::DIV_BITS'(ted_pkg::SAT_WORD))
                           ? ted_pkg::SAT_WORD : n1_in[31:0];
            inv_norm_ff <= (n2_in >= ted_pkg::DIV_BITS'(ted_pkg::SAT_WORD))
                           ? ted_pkg::SAT_WORD : n2_in[31:0];
         end
      end
   end

   // ---------------------------------------------------------------- assertions
   a_one_token : assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_vec))
      else $error("more than one derivation token in flight");

   a_token_state : assert property (@(posedge clock) disable iff (reset)
      tok_done |-> drv_state_ff == ted_pkg::DRV_WAIT)
      else $error("derivation token outside wait state");

   a_csr_starts : assert property (@(posedge clock) disable iff (reset)
      csr_accept |=> drv_state_ff == ted_pkg::DRV_INJECT && !req_tready)
      else $error("register write did not start derivation");

   a_sat_word : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == ted_pkg::SAT_WORD)
      else $error("saturated result not all ones");

endmodule

// ===== tb/truncated_exponential_density_tb.sv =====
// Testbench for the truncated exponential density: directed and random requests checked against a local predictor.
module truncated_exponential_density_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic OP_DENSITY = 1'b0;
   localparam logic OP_AREA    = 1'b1;
   localparam logic [2:0] CSR_UNUSED = 3'd7;
   localparam int FACTORS = ted_pkg::TBL_SIZE;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } density_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   density_result_type expected_results[$];
   int  mismatches = 0;
   bit  steady = 1'b0;

   // predictor state
   logic [63:0] factor_q32 [FACTORS];
   logic [31:0] rate;
   logic        lo_en;
   logic [31:0] lo_bound;
   logic        up_en;
   logic [31:0] up_bound;
   logic [63:0] inv_norm;
   logic [63:0] inv_rate_norm;

   truncated_exponential_density u_top (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic logic [63:0] series_factor(int j);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = 64'd1 << 62;
      term = 64'd1 << 62;
      for (int n = 1; n < 40; n++) begin
         term = (term >> j) / 64'(n);
         if (n % 2 == 1) sum = sum - term;
         else sum = sum + term;
      end
      return (sum + (64'd1 << 29)) >> 30;
   endfunction

   // exp(-p / 2^40) in Q0.32
   function automatic logic [63:0] exp_neg(logic [63:0] p);
      logic [63:0] t;
      logic [63:0] acc;
      logic [63:0] r;
      t   = p >> 8;
      acc = 64'd1 << 32;
      if ((t >> 37) != 0) return 64'd0;
      for (int k = 0; k < FACTORS; k++)
         if (t[36 - k]) acc = (acc * factor_q32[k] + (64'd1 << 31)) >> 32;
      r = t & ((64'd1 << ted_pkg::R_BITS) - 1);
      if (r != 0) acc = (acc * ((64'd1 << 32) - r) + (64'd1 << 31)) >> 32;
      return acc;
   endfunction

   function automatic logic [63:0] reciprocal(logic [63:0] num, logic [63:0] den);
      logic [63:0] q;
      if (den == 0) return 64'hFFFF_FFFF;
      q = (num + den / 2) / den;
      return (q >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic longint lower_limit();
      return lo_en ? longint'($signed(lo_bound)) : 0;
   endfunction

   function automatic void derive_normalisers();
      longint lo;
      longint hi;
      logic [63:0] den;
      lo  = lower_limit();
      hi  = longint'($signed(up_bound));
      den = 64'd1 << 32;
      if (up_en) den = (64'd1 << 32) - exp_neg(64'(rate) * ((hi > lo) ? 64'(hi - lo) : 64'd0));
      inv_rate_norm = reciprocal(64'd1 << 48, den);
      inv_norm      = reciprocal(64'(rate) << 24, den);
   endfunction

   function automatic density_result_type scale_result(logic [63:0] e, logic [63:0] k);
      density_result_type res;
      if (k == 64'hFFFF_FFFF) begin
         res.value = (e != 0) ? 32'hFFFF_FFFF : 32'd0;
         res.sat   = (e != 0);
      end else begin
         res.value = 32'((e * k + (64'd1 << 31)) >> 32);
         res.sat   = 1'b0;
      end
      return res;
   endfunction

   function automatic density_result_type predict_density(logic op, logic [31:0] pt,
                                                          logic [31:0] re);
      density_result_type res;
      longint lo;
      longint x;
      longint a;
      longint b;
      logic [63:0] ea;
      logic [63:0] eb;
      res = '0;
      lo  = lower_limit();
      x   = longint'($signed(pt));
      if (op == OP_DENSITY) begin
         if (x < lo || (up_en && x > longint'($signed(up_bound)))) return res;
         return scale_result(exp_neg(64'(rate) * 64'(x - lo)), inv_norm);
      end
      a = (x > lo) ? x : lo;
      b = longint'($signed(re));
      if (up_en && b > longint'($signed(up_bound))) b = longint'($signed(up_bound));
      if (b <= a) return res;
      ea = exp_neg(64'(rate) * 64'(a - lo));
      eb = exp_neg(64'(rate) * 64'(b - lo));
      return scale_result((ea > eb) ? ea - eb : 64'd0, inv_rate_norm);
   endfunction

   function automatic bit idle_now();
      return !steady && $urandom_range(0, 99) < 11;
   endfunction

   always @(posedge clock) begin
      if (!reset) rsp_tready <= !idle_now();
   end

   // compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      density_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result value %h sat %b", rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata !== want.value) begin
               $error("result_value expected %h actual %h", want.value, rsp_tdata);
               mismatches++;
            end
            if (rsp_tuser !== want.sat) begin
               $error("saturated expected %b actual %b", want.sat, rsp_tuser);
               mismatches++;
            end
         end
      end
   end

   task automatic send_request(logic op, logic [31:0] pt, logic [31:0] re);
      while (idle_now()) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {re, pt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(predict_density(op, pt, re));
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // block must be idle; hold off until the normalisers have settled
   task automatic write_csr(logic [2:0] idx, logic [31:0] data);
      csr_tvalid <= 1'b1;
      csr_index  <= idx;
      csr_wdata  <= data;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      csr_tvalid <= 1'b0;
      case (idx)
         ted_pkg::CSR_DECAY_RATE:   rate     = data;
         ted_pkg::CSR_LOWER_ENABLE: lo_en    = data[0];
         ted_pkg::CSR_LOWER_BOUND:  lo_bound = data;
         ted_pkg::CSR_UPPER_ENABLE: up_en    = data[0];
         ted_pkg::CSR_UPPER_BOUND:  up_bound = data;
         default: ;
      endcase
      derive_normalisers();
      repeat (100) @(posedge clock);
   endtask

   task automatic configure(logic [31:0] g, logic le, logic [31:0] lb, logic ue,
                            logic [31:0] ub);
      write_csr(ted_pkg::CSR_DECAY_RATE, g);
      write_csr(ted_pkg::CSR_LOWER_BOUND, lb);
      write_csr(ted_pkg::CSR_LOWER_ENABLE, {31'd0, le});
      write_csr(ted_pkg::CSR_UPPER_BOUND, ub);
      write_csr(ted_pkg::CSR_UPPER_ENABLE, {31'd0, ue});
   endtask

   task automatic test_reset_defaults();
      send_request(OP_DENSITY, 32'h0000_0000, 32'h0);
      send_request(OP_DENSITY, 32'h0001_0000, 32'hFFFF_FFFF);
      send_request(OP_DENSITY, 32'hFFFF_FFFF, 32'h0);
      send_request(OP_DENSITY, 32'h7FFF_FFFF, 32'h0);
      send_request(OP_DENSITY, 32'h8000_0000, 32'h0);
      send_request(OP_AREA, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_AREA, 32'h0000_0000, 32'h0001_0000);
      send_request(OP_AREA, 32'h0002_0000, 32'h0001_0000);
      send_request(OP_AREA, 32'h0001_0000, 32'h0001_0000);
      send_request(OP_AREA, 32'hFFFF_0000, 32'hFFFF_8000);
      drain();
   endtask

   task automatic test_limits();
      // limits at and around both cut-offs, then upper equal to lower (density saturates)
      configure(32'h0080_0000, 1'b1, 32'hFFFE_0000, 1'b1, 32'h0003_0000);
      send_request(OP_DENSITY, 32'hFFFE_0000, 32'h0);
      send_request(OP_DENSITY, 32'hFFFD_FFFF, 32'h0);
      send_request(OP_DENSITY, 32'h0003_0000, 32'h0);
      send_request(OP_DENSITY, 32'h0003_0001, 32'h0);
      send_request(OP_AREA, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_AREA, 32'h0000_0000, 32'h0001_0000);
      drain();
      configure(32'h0100_0000, 1'b1, 32'h0001_0000, 1'b1, 32'h0001_0000);
      send_request(OP_DENSITY, 32'h0001_0000, 32'h0);
      send_request(OP_DENSITY, 32'h0001_0001, 32'h0);
      send_request(OP_AREA, 32'h0000_0000, 32'h0002_0000);
      drain();
      // extreme rates, and an unused index that must change nothing
      configure(32'hFFFF_FFFF, 1'b0, 32'h0, 1'b1, 32'h0000_0100);
      write_csr(CSR_UNUSED, 32'hFFFF_FFFF);
      send_request(OP_DENSITY, 32'h0000_0000, 32'h0);
      send_request(OP_DENSITY, 32'h0000_0080, 32'h0);
      send_request(OP_AREA, 32'h0000_0000, 32'h0000_0100);
      drain();
      configure(32'h0000_0001, 1'b1, 32'h8000_0000, 1'b1, 32'h7FFF_FFFF);
      send_request(OP_DENSITY, 32'h8000_0000, 32'h0);
      send_request(OP_AREA, 32'h8000_0000, 32'h7FFF_FFFF);
      drain();
   endtask

   task automatic run_random_phase(int count);
      longint lo;
      logic [31:0] pt;
      logic [31:0] re;
      lo = lower_limit();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) == 0) begin
            pt = $urandom;
            re = $urandom;
         end else begin
            // mostly near the lower limit, where the density is alive
            pt = 32'(lo + $urandom_range(0, 32'h0008_0000) - 32'h0000_4000);
            re = 32'(longint'($signed(pt)) + $urandom_range(0, 32'h0008_0000));
         end
         send_request(1'($urandom_range(0, 1)), pt, re);
      end
      drain();
   endtask

   task automatic test_random();
      logic [31:0] lb;
      for (int phase = 0; phase < 10; phase++) begin
         steady = (phase == 4);
         lb = 32'($signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000);
         case (phase)
            0: configure(32'h0100_0000, 1'b0, 32'h0, 1'b0, 32'h0);
            1: configure(32'hFFFF_FFFF, 1'b1, lb, 1'b1, 32'(lb + 32'h0000_0400));
            2: configure(32'h0000_0001, 1'b1, 32'h8000_0000, 1'b0, 32'h7FFF_FFFF);
            default: configure($urandom_range(1, 32'h0800_0000), 1'($urandom), lb,
                               1'($urandom),
                               32'(lb + $urandom_range(0, 32'h0006_0000) - 32'h0000_8000));
         endcase
         run_random_phase(60);
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int k = 4; k < FACTORS; k++) factor_q32[k] = series_factor(k - 4);
      for (int k = 3; k >= 0; k--)
         factor_q32[k] = (factor_q32[k + 1] * factor_q32[k + 1] + (64'd1 << 31)) >> 32;
      rate     = 32'h0100_0000;
      lo_en    = 1'b0;
      lo_bound = '0;
      up_en    = 1'b0;
      up_bound = '0;
      derive_normalisers();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_limits();
      test_random();
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
